// ===== src/npm_pkg.sv =====
// Package with the item types, action codes and sequencer states of the n-gram pair matcher.
`timescale 1ns / 1ps
package npm_pkg;

  typedef enum logic [1:0] {
    ACT_APPEND_A = 2'd0,
    ACT_APPEND_B = 2'd1,
    ACT_FETCH    = 2'd2,
    ACT_CLEAR    = 2'd3
  } action_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SORT_START,
    ST_INIT,
    ST_CLR,
    ST_CNT_T,
    ST_CNT_C,
    ST_CNT_W,
    ST_PRE_R,
    ST_PRE_W,
    ST_SCA_O,
    ST_SCA_T,
    ST_SCA_C,
    ST_SCA_W,
    ST_CPY_R,
    ST_CPY_W,
    ST_SIDE_DONE,
    ST_M_CHK,
    ST_M_POS,
    ST_M_TXT,
    ST_M_CMP
  } state_e;

  localparam int unsigned RADIX = 256;
  localparam int unsigned POS_W = 16;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic             pair_found;
    logic [POS_W-1:0] pos_a;
    logic [POS_W-1:0] pos_b;
  } out_item_t;

endpackage

// ===== src/npm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module npm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/ngram_pair_matcher.sv =====
// Top level of the n-gram pair matcher: text stores, radix sort sequencer and merge.
`timescale 1ns / 1ps
// Appends and clears are taken in the idle state. The first fetch after any append or
// clear sorts the n-gram start positions of text A, then of text B, with one counting
// pass per n-gram byte, so the sort makes NGRAM_BYTES passes per text. Every fetch then
// steps the merge: each candidate pair is compared one byte at a time, up to NGRAM_BYTES
// bytes, through the single read port of each text store. All stores are single-port-read
// RAMs; the sequencer handles one item at a time and stalls input while it works or while
// a result waits to be taken. Positions are reported modulo 65536.
module ngram_pair_matcher
  import npm_pkg::*;
#(
  parameter int unsigned MAX_LEN     = 65536,
  parameter int unsigned NGRAM_BYTES = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int unsigned AW = $clog2(MAX_LEN);
  localparam int unsigned LW = AW + 1;
  localparam int unsigned JW = $clog2(NGRAM_BYTES + 1);
  localparam logic [LW-1:0] MAX_L  = LW'(MAX_LEN);
  localparam logic [LW-1:0] NG_L   = LW'(NGRAM_BYTES);
  localparam logic [JW-1:0] NG_TOP = JW'(NGRAM_BYTES - 1);

  state_e state_q, state_d;
  logic          side_q, side_d;
  logic [AW-1:0] i_q, i_d;
  logic [JW-1:0] j_q, j_d;
  logic [7:0]    k_q, k_d;
  logic [JW-1:0] ck_q, ck_d;
  logic [LW-1:0] sum_q, sum_d;
  logic [AW-1:0] p_q, p_d;
  logic [7:0]    c_q, c_d;
  logic [AW-1:0] pa_q, pa_d, pb_q, pb_d;
  logic [LW-1:0] ca_q, ca_d, cb_q, cb_d;
  logic [LW-1:0] len_a_q, len_a_d, len_b_q, len_b_d;
  logic          sorted_q, sorted_d;
  logic          out_valid_q, out_valid_d;
  out_item_t     out_q, out_d;

  logic          ta_we, tb_we;
  logic [AW-1:0] ta_waddr, tb_waddr, ta_raddr, tb_raddr;
  logic [7:0]    ta_rd, tb_rd;
  logic          oa_we, ob_we;
  logic [AW-1:0] o_waddr, o_wdata, oa_raddr, ob_raddr, oa_rd, ob_rd;
  logic          s_we;
  logic [AW-1:0] s_waddr, s_wdata, s_raddr, s_rd;
  logic          n_we;
  logic [7:0]    n_waddr, n_raddr;
  logic [LW-1:0] n_wdata, n_rd;

  logic          acc;
  logic          merging;
  logic [LW-1:0] na, nb, n_side;
  logic          last_i;
  logic [AW-1:0] sort_taddr;
  logic [7:0]    t_rd;
  logic [AW-1:0] o_rd;
  logic          o_we;
  logic [AW+POS_W-1:0] pa_wide, pb_wide;

  assign acc        = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE) || out_valid_q;
  assign na     = (len_a_q >= NG_L) ? len_a_q - NG_L + LW'(1) : '0;
  assign nb     = (len_b_q >= NG_L) ? len_b_q - NG_L + LW'(1) : '0;
  assign n_side = side_q ? nb : na;
  assign last_i = ({1'b0, i_q} == n_side - LW'(1));
  assign t_rd   = side_q ? tb_rd : ta_rd;
  assign o_rd   = side_q ? ob_rd : oa_rd;
  assign merging = (state_q == ST_M_CHK) || (state_q == ST_M_POS) ||
                   (state_q == ST_M_TXT) || (state_q == ST_M_CMP);
  assign ta_raddr = merging ? pa_q + AW'(ck_q) : sort_taddr;
  assign tb_raddr = merging ? pb_q + AW'(ck_q) : sort_taddr;
  assign oa_we    = o_we && !side_q;
  assign ob_we    = o_we && side_q;
  assign pa_wide  = {{POS_W{1'b0}}, pa_q};
  assign pb_wide  = {{POS_W{1'b0}}, pb_q};

  always_comb begin
    state_d     = state_q;
    side_d      = side_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    ck_d        = ck_q;
    sum_d       = sum_q;
    p_d         = p_q;
    c_d         = c_q;
    pa_d        = pa_q;
    pb_d        = pb_q;
    ca_d        = ca_q;
    cb_d        = cb_q;
    len_a_d     = len_a_q;
    len_b_d     = len_b_q;
    sorted_d    = sorted_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    ta_we       = 1'b0;
    tb_we       = 1'b0;
    ta_waddr    = len_a_q[AW-1:0];
    tb_waddr    = len_b_q[AW-1:0];
    o_we        = 1'b0;
    o_waddr     = i_q;
    o_wdata     = i_q;
    oa_raddr    = i_q;
    ob_raddr    = i_q;
    s_we        = 1'b0;
    s_waddr     = n_rd[AW-1:0];
    s_wdata     = p_q;
    s_raddr     = i_q;
    n_we        = 1'b0;
    n_waddr     = c_q;
    n_wdata     = n_rd + LW'(1);
    n_raddr     = c_q;
    sort_taddr  = i_q + AW'(j_q);

    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          case (in_item_i.action)
            ACT_APPEND_A: begin
              if (len_a_q < MAX_L) begin
                ta_we   = 1'b1;
                len_a_d = len_a_q + LW'(1);
              end
              sorted_d = 1'b0;
              ca_d     = '0;
              cb_d     = '0;
            end
            ACT_APPEND_B: begin
              if (len_b_q < MAX_L) begin
                tb_we   = 1'b1;
                len_b_d = len_b_q + LW'(1);
              end
              sorted_d = 1'b0;
              ca_d     = '0;
              cb_d     = '0;
            end
            ACT_CLEAR: begin
              len_a_d  = '0;
              len_b_d  = '0;
              sorted_d = 1'b0;
              ca_d     = '0;
              cb_d     = '0;
            end
            default: begin
              if (sorted_q) begin
                state_d = ST_M_CHK;
              end else begin
                side_d  = 1'b0;
                state_d = ST_SORT_START;
              end
            end
          endcase
        end
      end
      ST_SORT_START: begin
        i_d = '0;
        j_d = '0;
        k_d = '0;
        state_d = (n_side == '0) ? ST_SIDE_DONE : ST_INIT;
      end
      ST_INIT: begin
        o_we = 1'b1;
        i_d  = i_q + AW'(1);
        if (last_i) begin
          k_d     = '0;
          state_d = ST_CLR;
        end
      end
      ST_CLR: begin
        n_we    = 1'b1;
        n_waddr = k_q;
        n_wdata = '0;
        k_d     = k_q + 8'd1;
        if (k_q == 8'hFF) begin
          i_d     = '0;
          state_d = ST_CNT_T;
        end
      end
      ST_CNT_T: begin
        state_d = ST_CNT_C;
      end
      ST_CNT_C: begin
        c_d     = t_rd;
        n_raddr = t_rd;
        state_d = ST_CNT_W;
      end
      ST_CNT_W: begin
        n_we = 1'b1;
        i_d  = i_q + AW'(1);
        if (last_i) begin
          k_d     = '0;
          sum_d   = '0;
          state_d = ST_PRE_R;
        end else begin
          state_d = ST_CNT_T;
        end
      end
      ST_PRE_R: begin
        n_raddr = k_q;
        state_d = ST_PRE_W;
      end
      ST_PRE_W: begin
        n_we    = 1'b1;
        n_waddr = k_q;
        n_wdata = sum_q;
        sum_d   = sum_q + n_rd;
        k_d     = k_q + 8'd1;
        if (k_q == 8'hFF) begin
          i_d     = '0;
          state_d = ST_SCA_O;
        end else begin
          state_d = ST_PRE_R;
        end
      end
      ST_SCA_O: begin
        state_d = ST_SCA_T;
      end
      ST_SCA_T: begin
        p_d        = o_rd;
        sort_taddr = o_rd + AW'(j_q);
        state_d    = ST_SCA_C;
      end
      ST_SCA_C: begin
        c_d     = t_rd;
        n_raddr = t_rd;
        state_d = ST_SCA_W;
      end
      ST_SCA_W: begin
        s_we = 1'b1;
        n_we = 1'b1;
        i_d  = i_q + AW'(1);
        if (last_i) begin
          i_d     = '0;
          state_d = ST_CPY_R;
        end else begin
          state_d = ST_SCA_O;
        end
      end
      ST_CPY_R: begin
        state_d = ST_CPY_W;
      end
      ST_CPY_W: begin
        o_we    = 1'b1;
        o_wdata = s_rd;
        i_d     = i_q + AW'(1);
        if (last_i) begin
          if (j_q == NG_TOP) begin
            state_d = ST_SIDE_DONE;
          end else begin
            j_d     = j_q + JW'(1);
            k_d     = '0;
            state_d = ST_CLR;
          end
        end else begin
          state_d = ST_CPY_R;
        end
      end
      ST_SIDE_DONE: begin
        if (!side_q) begin
          side_d  = 1'b1;
          state_d = ST_SORT_START;
        end else begin
          sorted_d = 1'b1;
          ca_d     = '0;
          cb_d     = '0;
          state_d  = ST_M_CHK;
        end
      end
      ST_M_CHK: begin
        oa_raddr = ca_q[AW-1:0];
        ob_raddr = cb_q[AW-1:0];
        if ((ca_q < na) && (cb_q < nb)) begin
          state_d = ST_M_POS;
        end else begin
          out_valid_d = 1'b1;
          out_d       = '0;
          state_d     = ST_IDLE;
        end
      end
      ST_M_POS: begin
        pa_d    = oa_rd;
        pb_d    = ob_rd;
        ck_d    = NG_TOP;
        state_d = ST_M_TXT;
      end
      ST_M_TXT: begin
        state_d = ST_M_CMP;
      end
      ST_M_CMP: begin
        if (ta_rd < tb_rd) begin
          ca_d    = ca_q + LW'(1);
          state_d = ST_M_CHK;
        end else if (ta_rd > tb_rd) begin
          cb_d    = cb_q + LW'(1);
          state_d = ST_M_CHK;
        end else if (ck_q == '0) begin
          ca_d             = ca_q + LW'(1);
          cb_d             = cb_q + LW'(1);
          out_valid_d      = 1'b1;
          out_d.pair_found = 1'b1;
          out_d.pos_a      = pa_wide[POS_W-1:0];
          out_d.pos_b      = pb_wide[POS_W-1:0];
          state_d          = ST_IDLE;
        end else begin
          ck_d    = ck_q - JW'(1);
          state_d = ST_M_TXT;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      side_q      <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      ck_q        <= '0;
      ca_q        <= '0;
      cb_q        <= '0;
      len_a_q     <= '0;
      len_b_q     <= '0;
      sorted_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      side_q      <= side_d;
      i_q         <= i_d;
      j_q         <= j_d;
      k_q         <= k_d;
      ck_q        <= ck_d;
      ca_q        <= ca_d;
      cb_q        <= cb_d;
      len_a_q     <= len_a_d;
      len_b_q     <= len_b_d;
      sorted_q    <= sorted_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    p_q   <= p_d;
    c_q   <= c_d;
    pa_q  <= pa_d;
    pb_q  <= pb_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  npm_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_text_a (
    .clk_i(clk_i), .we_i(ta_we), .waddr_i(ta_waddr), .wdata_i(in_item_i.data_byte),
    .raddr_i(ta_raddr), .rdata_o(ta_rd)
  );

  npm_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_text_b (
    .clk_i(clk_i), .we_i(tb_we), .waddr_i(tb_waddr), .wdata_i(in_item_i.data_byte),
    .raddr_i(tb_raddr), .rdata_o(tb_rd)
  );

  npm_ram #(.WIDTH(AW), .DEPTH(MAX_LEN)) u_order_a (
    .clk_i(clk_i), .we_i(oa_we), .waddr_i(o_waddr), .wdata_i(o_wdata),
    .raddr_i(oa_raddr), .rdata_o(oa_rd)
  );

  npm_ram #(.WIDTH(AW), .DEPTH(MAX_LEN)) u_order_b (
    .clk_i(clk_i), .we_i(ob_we), .waddr_i(o_waddr), .wdata_i(o_wdata),
    .raddr_i(ob_raddr), .rdata_o(ob_rd)
  );

  npm_ram #(.WIDTH(AW), .DEPTH(MAX_LEN)) u_scratch (
    .clk_i(clk_i), .we_i(s_we), .waddr_i(s_waddr), .wdata_i(s_wdata),
    .raddr_i(s_raddr), .rdata_o(s_rd)
  );

  npm_ram #(.WIDTH(LW), .DEPTH(RADIX)) u_counts (
    .clk_i(clk_i), .we_i(n_we), .waddr_i(n_waddr), .wdata_i(n_wdata),
    .raddr_i(n_raddr), .rdata_o(n_rd)
  );

  a_fetch_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && (in_item_i.action == ACT_FETCH) |=> state_q != ST_IDLE)
    else $error("fetch did not start the sequencer");

  a_cursor_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sorted_q |-> (ca_q <= na) && (cb_q <= nb))
    else $error("merge cursor past end of list");

  a_done_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) && !out_q.pair_found |-> (out_q.pos_a == '0) && (out_q.pos_b == '0))
    else $error("done mark carries nonzero positions");

endmodule
